// ===== hdl/keyed_three_class_priority_queue_top_defines.svh =====
// ---------------------------------------------------------------------------
// keyed three-class priority queue: assertion macros
// shared check forms for the queue's concurrent assertions
// ---------------------------------------------------------------------------
`ifndef KEYED_THREE_CLASS_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define KEYED_THREE_CLASS_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kpq_pkg.sv =====
// ---------------------------------------------------------------------------
// kpq_pkg
// types and codes of the keyed three-class priority queue
// ---------------------------------------------------------------------------
`default_nettype none

package kpq_pkg;

  localparam int CAP_DEFAULT = 256;

  typedef enum logic [1:0] {
    REQ_ADMIT  = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_NEXT   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_POST,
    S_ADM_RD,
    S_ADM_WR,
    S_REM_L,
    S_REM_ORD,
    S_REM_OWR,
    S_REM_NRD,
    S_REM_NWR,
    S_NEXT_RD,
    S_NEXT_DT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] patient_code;
    logic [7:0]  age_in;
    logic [1:0]  severity_in;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_code;
    logic [1:0]  next_severity;
    logic [7:0]  found_age;
    logic        any_waiting;
  } out_t;

  typedef struct packed {
    logic [31:0] code;
    logic [7:0]  age;
    logic [1:0]  sev;
  } ent_t;

endpackage

`default_nettype wire

// ===== hdl/kpq_core.sv =====
// ---------------------------------------------------------------------------
// kpq_core
// entry and link memories, code scan and per-class list maintenance
// ---------------------------------------------------------------------------
`default_nettype none

module kpq_core #(
  parameter int CAPACITY = kpq_pkg::CAP_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  kpq_pkg::in_t   in_data,
  output logic           res_valid,
  input  logic           res_take,
  output kpq_pkg::out_t  res_data
);

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PTRW = $clog2(CAPACITY + 1);
  localparam logic [PTRW-1:0] NULL_PTR = PTRW'(CAPACITY);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);

  typedef struct packed {
    logic [PTRW-1:0] older;
    logic [PTRW-1:0] newer;
  } link_t;

  kpq_pkg::ent_t ent_mem [CAPACITY];
  link_t         link_mem [CAPACITY];
  kpq_pkg::ent_t ent_q;
  link_t         link_q;

  logic [CAPACITY-1:0] vbit;

  kpq_pkg::state_e  st, st_next;
  kpq_pkg::req_e    req;
  logic [31:0]      code;
  logic [7:0]       age;
  logic [1:0]       sev;
  logic [PTRW-1:0]  rd_cnt;
  logic             p_valid;
  logic [IDXW-1:0]  p_idx;
  logic             found;
  logic [IDXW-1:0]  hit_idx;
  logic [7:0]       hit_age;
  logic [1:0]       hit_sev;
  logic             free_ok;
  logic [IDXW-1:0]  free_idx;
  logic [PTRW-1:0]  used;
  logic [PTRW-1:0]  head [3];
  logic [PTRW-1:0]  tail [3];
  logic [PTRW-1:0]  lnk_o, lnk_n;
  kpq_pkg::status_e rstat;
  logic [31:0]      rcode;
  logic [7:0]       rage;
  logic [1:0]       rnsev;

  logic            hit, scan_end, any_class;
  logic [1:0]      pick;
  logic [IDXW-1:0] ent_ra, link_ra, link_wa;
  logic            ent_we, link_we;
  link_t           link_wd;

  assign hit      = p_valid && vbit[p_idx] && (ent_q.code == code);
  assign scan_end = p_valid && (p_idx == LAST_IDX);

  // most severe non-empty class
  always_comb begin
    any_class = 1'b1;
    pick      = 2'd0;
    priority if (head[0] != NULL_PTR) begin
      pick = 2'd0;
    end else if (head[1] != NULL_PTR) begin
      pick = 2'd1;
    end else if (head[2] != NULL_PTR) begin
      pick = 2'd2;
    end else begin
      any_class = 1'b0;
    end
  end

  assign ent_ra = (st == kpq_pkg::S_SCAN) ? rd_cnt[IDXW-1:0] : head[pick][IDXW-1:0];

  always_ff @(posedge clk) begin
    ent_q  <= ent_mem[ent_ra];
    link_q <= link_mem[link_ra];
    if (ent_we) begin
      ent_mem[free_idx] <= '{code: code, age: age, sev: sev};
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= kpq_pkg::S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next   = st;
    in_stall  = (st != kpq_pkg::S_IDLE);
    res_valid = (st == kpq_pkg::S_RESP);
    ent_we    = 1'b0;
    link_we   = 1'b0;
    link_wa   = free_idx;
    link_wd   = '{older: tail[sev], newer: NULL_PTR};
    link_ra   = hit_idx;
    unique case (st)
      kpq_pkg::S_IDLE: begin
        if (in_valid) begin
          st_next = (kpq_pkg::req_e'(in_data.req_type) == kpq_pkg::REQ_NEXT) ?
                    kpq_pkg::S_NEXT_RD : kpq_pkg::S_SCAN;
        end
      end
      kpq_pkg::S_SCAN: begin
        if (hit || scan_end) begin
          st_next = kpq_pkg::S_POST;
        end
      end
      kpq_pkg::S_POST: begin
        link_ra = hit_idx;
        st_next = kpq_pkg::S_RESP;
        unique case (req)
          kpq_pkg::REQ_ADMIT: begin
            if (!found && used != NULL_PTR) begin
              ent_we  = 1'b1;
              link_we = 1'b1;
              if (tail[sev] != NULL_PTR) begin
                st_next = kpq_pkg::S_ADM_RD;
              end
            end
          end
          kpq_pkg::REQ_REMOVE: begin
            if (found) begin
              st_next = kpq_pkg::S_REM_L;
            end
          end
          kpq_pkg::REQ_LOOKUP, kpq_pkg::REQ_NEXT: begin
          end
        endcase
      end
      kpq_pkg::S_ADM_RD: begin
        link_ra = lnk_o[IDXW-1:0];
        st_next = kpq_pkg::S_ADM_WR;
      end
      kpq_pkg::S_ADM_WR: begin
        link_we = 1'b1;
        link_wa = lnk_o[IDXW-1:0];
        link_wd = '{older: link_q.older, newer: PTRW'(free_idx)};
        st_next = kpq_pkg::S_RESP;
      end
      kpq_pkg::S_REM_L: begin
        if (link_q.older != NULL_PTR) begin
          st_next = kpq_pkg::S_REM_ORD;
        end else if (link_q.newer != NULL_PTR) begin
          st_next = kpq_pkg::S_REM_NRD;
        end else begin
          st_next = kpq_pkg::S_RESP;
        end
      end
      kpq_pkg::S_REM_ORD: begin
        link_ra = lnk_o[IDXW-1:0];
        st_next = kpq_pkg::S_REM_OWR;
      end
      kpq_pkg::S_REM_OWR: begin
        link_we = 1'b1;
        link_wa = lnk_o[IDXW-1:0];
        link_wd = '{older: link_q.older, newer: lnk_n};
        st_next = (lnk_n != NULL_PTR) ? kpq_pkg::S_REM_NRD : kpq_pkg::S_RESP;
      end
      kpq_pkg::S_REM_NRD: begin
        link_ra = lnk_n[IDXW-1:0];
        st_next = kpq_pkg::S_REM_NWR;
      end
      kpq_pkg::S_REM_NWR: begin
        link_we = 1'b1;
        link_wa = lnk_n[IDXW-1:0];
        link_wd = '{older: lnk_o, newer: link_q.newer};
        st_next = kpq_pkg::S_RESP;
      end
      kpq_pkg::S_NEXT_RD: begin
        st_next = any_class ? kpq_pkg::S_NEXT_DT : kpq_pkg::S_RESP;
      end
      kpq_pkg::S_NEXT_DT: begin
        st_next = kpq_pkg::S_RESP;
      end
      kpq_pkg::S_RESP: begin
        if (res_take) begin
          st_next = kpq_pkg::S_IDLE;
        end
      end
      default: begin
        st_next = kpq_pkg::S_IDLE;
      end
    endcase
  end

  // control state and list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
      used <= '0;
      for (int c = 0; c < 3; c++) begin
        head[c] <= NULL_PTR;
        tail[c] <= NULL_PTR;
      end
    end else begin
      unique case (st)
        kpq_pkg::S_POST: begin
          if (req == kpq_pkg::REQ_ADMIT && !found && used != NULL_PTR) begin
            vbit[free_idx] <= 1'b1;
            used           <= used + 1'b1;
            tail[sev]      <= PTRW'(free_idx);
            if (tail[sev] == NULL_PTR) begin
              head[sev] <= PTRW'(free_idx);
            end
          end
          if (req == kpq_pkg::REQ_REMOVE && found) begin
            vbit[hit_idx] <= 1'b0;
            used          <= used - 1'b1;
          end
        end
        kpq_pkg::S_REM_L: begin
          if (link_q.older == NULL_PTR) begin
            head[hit_sev] <= link_q.newer;
          end
          if (link_q.newer == NULL_PTR) begin
            tail[hit_sev] <= link_q.older;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request payload, scan progress and result fields
  always_ff @(posedge clk) begin
    unique case (st)
      kpq_pkg::S_IDLE: begin
        req     <= kpq_pkg::req_e'(in_data.req_type);
        code    <= in_data.patient_code;
        age     <= in_data.age_in;
        sev     <= (in_data.severity_in == 2'd3) ? 2'd2 : in_data.severity_in;
        rd_cnt  <= '0;
        p_valid <= 1'b0;
        found   <= 1'b0;
        free_ok <= 1'b0;
        rstat   <= kpq_pkg::ST_OK;
        rcode   <= '0;
        rage    <= '0;
        rnsev   <= '0;
      end
      kpq_pkg::S_SCAN: begin
        if (rd_cnt != NULL_PTR) begin
          rd_cnt  <= rd_cnt + 1'b1;
          p_valid <= 1'b1;
          p_idx   <= rd_cnt[IDXW-1:0];
          if (!vbit[rd_cnt[IDXW-1:0]] && !free_ok) begin
            free_ok  <= 1'b1;
            free_idx <= rd_cnt[IDXW-1:0];
          end
        end else begin
          p_valid <= 1'b0;
        end
        if (hit) begin
          found   <= 1'b1;
          hit_idx <= p_idx;
          hit_age <= ent_q.age;
          hit_sev <= ent_q.sev;
        end
      end
      kpq_pkg::S_POST: begin
        unique case (req)
          kpq_pkg::REQ_ADMIT: begin
            lnk_o <= tail[sev];
            if (found) begin
              rstat <= kpq_pkg::ST_DUP;
            end else if (used == NULL_PTR) begin
              rstat <= kpq_pkg::ST_FULL;
            end
          end
          kpq_pkg::REQ_LOOKUP: begin
            if (found) begin
              rage <= hit_age;
            end else begin
              rstat <= kpq_pkg::ST_NOTFOUND;
            end
          end
          kpq_pkg::REQ_REMOVE: begin
            if (!found) begin
              rstat <= kpq_pkg::ST_NOTFOUND;
            end
          end
          kpq_pkg::REQ_NEXT: begin
          end
        endcase
      end
      kpq_pkg::S_REM_L: begin
        lnk_o <= link_q.older;
        lnk_n <= link_q.newer;
      end
      kpq_pkg::S_NEXT_RD: begin
        rnsev <= pick;
        if (!any_class) begin
          rstat <= kpq_pkg::ST_EMPTY;
        end
      end
      kpq_pkg::S_NEXT_DT: begin
        rcode <= ent_q.code;
        if (rnsev == 2'd0) begin
          rnsev <= 2'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_data = '{status:        rstat,
                      next_code:     rcode,
                      next_severity: rnsev,
                      found_age:     rage,
                      any_waiting:   (used != '0)};

endmodule

`default_nettype wire

// ===== hdl/keyed_three_class_priority_queue_top.sv =====
// ---------------------------------------------------------------------------
// keyed_three_class_priority_queue_top
// three-class keyed waiting queue with a registered result word
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | to block  | in_valid / in_stall   | kpq_pkg::in_t
//  out     | from block| out_valid / out_stall | kpq_pkg::out_t
//
//  admit, lookup and remove scan the entry memory one slot per cycle,
//  stopping at a hit or the last slot; admit and remove then update list links
//  query next reads the head entry; with every class empty it skips that read
//  one word in flight; the result register frees the core while it waits
//  reset clears the per-slot valid flags at once, no clearing pass
//  out_stall holds the result register and then the core, never drops a word
// ---------------------------------------------------------------------------
`default_nettype none
`include "keyed_three_class_priority_queue_top_defines.svh"

module keyed_three_class_priority_queue_top #(
  parameter int CAPACITY = kpq_pkg::CAP_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  kpq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output kpq_pkg::out_t out_data
);

  logic          res_valid;
  logic          res_take;
  kpq_pkg::out_t res_data;

  kpq_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_take (res_take),
    .res_data (res_data)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data <= res_data;
    end
  end

  `KPQ_ASSERT_NOW(a_empty_none_waiting, out_valid && out_data.status == kpq_pkg::ST_EMPTY, !out_data.any_waiting, "empty result with entries waiting")
  `KPQ_ASSERT_NOW(a_full_some_waiting, out_valid && out_data.status == kpq_pkg::ST_FULL, out_data.any_waiting, "full result with nothing waiting")
  `KPQ_ASSERT_NOW(a_busy_while_result, res_valid, in_stall, "core takes a word while a result is pending")
  `KPQ_ASSERT_NEXT(a_result_lands, res_valid && res_take, out_valid && !res_valid, "taken result not in output register")

endmodule

`default_nettype wire
